// File: src/gmapt_pkg.sv
// gmapt_pkg: shared widths, types and constants of the grid max-area path block
// used by the channel interfaces and by grid_max_area_path_traceback
// no dependencies
package gmapt_pkg;

	localparam int RATE_W    = 16;
	localparam int SIZE_W    = 6;
	localparam int SCORE_W   = 40;
	localparam int DIFF_W    = RATE_W + 1;
	localparam int PROD_W    = DIFF_W + DIFF_W + 1;
	localparam int CFG_IDX_W = 1;

	typedef logic [RATE_W-1:0]         rate_t;
	typedef logic [SIZE_W-1:0]         size_t;
	typedef logic signed [SCORE_W-1:0] score_t;
	typedef logic signed [SCORE_W:0]   score_wide_t;
	typedef logic signed [PROD_W-1:0]  prod_t;

	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;

	localparam score_t SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
	localparam score_t SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

endpackage

// File: src/gmapt_if.sv
// gmapt_if: valid/ready channels of the grid max-area path block
// gmapt_in_if carries one grid cell, gmapt_out_if one path word
// depends on gmapt_pkg
interface gmapt_in_if;
	logic              valid;
	logic              ready;
	gmapt_pkg::rate_t  fpr_value;
	gmapt_pkg::rate_t  tpr_value;

	modport source(output valid, output fpr_value, output tpr_value, input ready);
	modport sink(input valid, input fpr_value, input tpr_value, output ready);
endinterface

interface gmapt_out_if;
	logic              valid;
	logic              ready;
	gmapt_pkg::size_t  step_index;
	gmapt_pkg::size_t  path_row;
	gmapt_pkg::size_t  path_col;
	logic              is_last;

	modport source(output valid, output step_index, output path_row, output path_col,
		output is_last, input ready);
	modport sink(input valid, input step_index, input path_row, input path_col,
		input is_last, output ready);
endinterface

// File: src/grid_max_area_path_traceback.sv
// Grid max-area monotone path with traceback. Cells arrive row-major on grid, one per
// word; a first-row cell takes accept, left and finish steps, any other cell an upper
// step too (one shared 17x18 multiplier and one shared add/saturate used for the upper
// and the left trapezoid in turn). One decision bit per cell goes to a 2^(row bits +
// col bits) entry memory. After the last cell the block walks back from the far corner
// (registered read of the decision memory each step), then sends rows+cols-1 path words
// on trace, each held until downstream takes it. A write of row_count or col_count
// realigns the cell position before the next cell is taken: a limit and a check step,
// then a bitwise division of the position (10 bits at the default size) when it stays
// inside the new grid. There is no clearing pass after reset.
// depends on gmapt_pkg and gmapt_if
module grid_max_area_path_traceback #(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	gmapt_in_if.sink                            grid,
	gmapt_out_if.source                         trace,
	input  logic                                cfg_we,
	input  logic [gmapt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gmapt_pkg::SIZE_W-1:0]        cfg_data
);

	localparam int SW     = gmapt_pkg::SIZE_W;
	localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int CELLS  = MAX_ROWS * MAX_COLS;
	localparam int PW     = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int LW     = PW + 1;
	localparam int DW     = $clog2(PW + 1);
	localparam int DEC_N  = 1 << (RW + CW);
	localparam int PATH_N = MAX_ROWS + MAX_COLS - 1;
	localparam int PIW    = (PATH_N > 1) ? $clog2(PATH_N) : 1;

	typedef enum logic [3:0] {
		IDLE, N_LIM, N_CHK, N_DIV, C_UP, C_LEFT, C_FIN, T_RD, T_STEP, E_RD, E_LOAD, E_WAIT
	} state_t;

	function automatic gmapt_pkg::size_t clamp_size(input gmapt_pkg::size_t v,
		input gmapt_pkg::size_t m);
		gmapt_pkg::size_t r;
		if (v == '0)
			r = SW'(1);
		else if (v > m)
			r = m;
		else
			r = v;
		return r;
	endfunction

	state_t                 state_q;
	logic                   dirty_q;
	gmapt_pkg::size_t       rows_q, cols_q;
	logic [LW-1:0]          limit_q;
	logic [PW-1:0]          pos_q;
	logic [RW-1:0]          row_q;
	logic [CW-1:0]          col_q;
	logic [PW-1:0]          div_q;
	gmapt_pkg::size_t       rem_q;
	logic [DW-1:0]          dcnt_q;
	gmapt_pkg::rate_t       f_q, t_q;
	gmapt_pkg::rate_t       left_f_q, left_t_q;
	gmapt_pkg::score_t      left_s_q;
	gmapt_pkg::prod_t       prod_q;
	gmapt_pkg::score_t      base_q;
	gmapt_pkg::score_t      cand_up_q;
	logic [RW-1:0]          ti_q;
	logic [CW-1:0]          tj_q;
	gmapt_pkg::size_t       k_q;
	logic                   out_valid_q;
	gmapt_pkg::size_t       step_q, prow_q, pcol_q;
	logic                   last_q;

	// storage
	logic                   dec_mem [DEC_N];
	logic                   dec_rd_q;
	gmapt_pkg::rate_t       up_f_mem [MAX_COLS];
	gmapt_pkg::rate_t       up_t_mem [MAX_COLS];
	gmapt_pkg::score_t      up_s_mem [MAX_COLS];
	gmapt_pkg::rate_t       up_f_rd_q, up_t_rd_q;
	gmapt_pkg::score_t      up_s_rd_q;
	gmapt_pkg::size_t       path_mem [PATH_N];
	gmapt_pkg::size_t       path_rd_q;

	logic                   is_origin;
	gmapt_pkg::rate_t       op_f, op_t;
	gmapt_pkg::score_t      op_s;
	logic signed [gmapt_pkg::DIFF_W-1:0] mul_a;
	logic [gmapt_pkg::DIFF_W-1:0]        t_sum;
	logic signed [gmapt_pkg::DIFF_W:0]   mul_b;
	gmapt_pkg::prod_t       mul_p;
	gmapt_pkg::score_wide_t sum_w;
	gmapt_pkg::score_t      sum_sat;
	logic                   take_up;
	gmapt_pkg::score_t      score_new;
	logic                   last_cell;
	logic [2*SW-1:0]        area;
	logic [SW:0]            div_r;
	logic                   div_ge;
	logic [PW-1:0]          div_next;
	gmapt_pkg::size_t       rem_next;
	logic                   ti_dec;
	logic [RW-1:0]          ti_next;
	logic [CW-1:0]          tj_next;
	gmapt_pkg::size_t       tsum;
	logic [SW:0]            count_m1;
	gmapt_pkg::size_t       emit_row;
	logic                   dec_we, up_we, path_we;

	assign grid.ready  = (state_q == IDLE) && !dirty_q;
	assign trace.valid = out_valid_q;
	assign trace.step_index = step_q;
	assign trace.path_row   = prow_q;
	assign trace.path_col   = pcol_q;
	assign trace.is_last    = last_q;

	// shared multiply: (fpr - fpr_n) * (tpr + tpr_n)
	assign is_origin = (row_q == '0) && (col_q == '0);
	always_comb begin
		if (state_q == C_UP) begin
			op_f = up_f_rd_q;
			op_t = up_t_rd_q;
			op_s = up_s_rd_q;
		end else if (is_origin) begin
			op_f = '0;
			op_t = '0;
			op_s = '0;
		end else begin
			op_f = left_f_q;
			op_t = left_t_q;
			op_s = left_s_q;
		end
	end
	assign mul_a = $signed({1'b0, f_q}) - $signed({1'b0, op_f});
	assign t_sum = {1'b0, t_q} + {1'b0, op_t};
	assign mul_b = $signed({1'b0, t_sum});
	assign mul_p = mul_a * mul_b;

	// shared add and saturate, halving floors
	assign sum_w   = gmapt_pkg::score_wide_t'(base_q) + gmapt_pkg::score_wide_t'(prod_q >>> 1);
	assign sum_sat = (sum_w[gmapt_pkg::SCORE_W] != sum_w[gmapt_pkg::SCORE_W-1]) ?
		(sum_w[gmapt_pkg::SCORE_W] ? gmapt_pkg::SCORE_MIN : gmapt_pkg::SCORE_MAX) :
		gmapt_pkg::score_t'(sum_w);

	// tie goes to the upper neighbor
	always_comb begin
		if (row_q == '0)
			take_up = 1'b0;
		else if (col_q == '0)
			take_up = 1'b1;
		else
			take_up = !(cand_up_q < sum_sat);
	end
	assign score_new = take_up ? cand_up_q : sum_sat;
	assign last_cell = (LW'(pos_q) + LW'(1)) == limit_q;
	assign area      = rows_q * cols_q;

	// one quotient bit per cycle while realigning the position
	assign div_r    = {rem_q, div_q[PW-1]};
	assign div_ge   = div_r >= {1'b0, cols_q};
	assign div_next = PW'({div_q, div_ge});
	assign rem_next = div_ge ? SW'(div_r - {1'b0, cols_q}) : SW'(div_r);

	// a first-column cell always goes up, which also keeps the walk in range
	assign ti_dec  = (ti_q != '0) && (dec_rd_q || (tj_q == '0));
	assign ti_next = ti_dec ? ti_q - RW'(1) : ti_q;
	assign tj_next = ti_dec ? tj_q : tj_q - CW'(1);
	assign tsum    = SW'(ti_q) + SW'(tj_q);

	assign count_m1 = {1'b0, rows_q} + {1'b0, cols_q} - (SW+1)'(2);
	assign emit_row = (k_q == '0) ? SW'(1) : path_rd_q;

	assign dec_we  = (state_q == C_FIN);
	assign up_we   = (state_q == C_FIN);
	assign path_we = (state_q == T_STEP);

	always_ff @(posedge clk) begin
		if (dec_we)
			dec_mem[{row_q, col_q}] <= take_up;
		dec_rd_q <= dec_mem[{ti_q, tj_q}];
	end

	always_ff @(posedge clk) begin
		if (up_we) begin
			up_f_mem[col_q] <= f_q;
			up_t_mem[col_q] <= t_q;
			up_s_mem[col_q] <= score_new;
		end
		up_f_rd_q <= up_f_mem[col_q];
		up_t_rd_q <= up_t_mem[col_q];
		up_s_rd_q <= up_s_mem[col_q];
	end

	always_ff @(posedge clk) begin
		if (path_we)
			path_mem[tsum[PIW-1:0]] <= SW'(ti_q) + SW'(1);
		path_rd_q <= path_mem[k_q[PIW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			dirty_q     <= 1'b0;
			rows_q      <= clamp_size(SW'(32), SW'(MAX_ROWS));
			cols_q      <= clamp_size(SW'(32), SW'(MAX_COLS));
			limit_q     <= LW'(CELLS);
			pos_q       <= '0;
			row_q       <= '0;
			col_q       <= '0;
			div_q       <= '0;
			rem_q       <= '0;
			dcnt_q      <= '0;
			f_q         <= '0;
			t_q         <= '0;
			left_f_q    <= '0;
			left_t_q    <= '0;
			left_s_q    <= '0;
			prod_q      <= '0;
			base_q      <= '0;
			cand_up_q   <= '0;
			ti_q        <= '0;
			tj_q        <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			step_q      <= '0;
			prow_q      <= '0;
			pcol_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					if (dirty_q) begin
						state_q <= N_LIM;
					end else if (grid.valid) begin
						f_q     <= grid.fpr_value;
						t_q     <= grid.tpr_value;
						state_q <= (row_q == '0) ? C_LEFT : C_UP;
					end
				end
				N_LIM: begin
					limit_q <= area[LW-1:0];
					state_q <= N_CHK;
				end
				N_CHK: begin
					if (LW'(pos_q) >= limit_q) begin
						pos_q   <= '0;
						row_q   <= '0;
						col_q   <= '0;
						dirty_q <= 1'b0;
						state_q <= IDLE;
					end else begin
						div_q   <= pos_q;
						rem_q   <= '0;
						dcnt_q  <= DW'(PW);
						state_q <= N_DIV;
					end
				end
				N_DIV: begin
					div_q  <= div_next;
					rem_q  <= rem_next;
					dcnt_q <= dcnt_q - DW'(1);
					if (dcnt_q == DW'(1)) begin
						row_q   <= RW'(div_next);
						col_q   <= CW'(rem_next);
						dirty_q <= 1'b0;
						state_q <= IDLE;
					end
				end
				C_UP: begin
					prod_q  <= mul_p;
					base_q  <= op_s;
					state_q <= C_LEFT;
				end
				C_LEFT: begin
					cand_up_q <= sum_sat;
					prod_q    <= mul_p;
					base_q    <= op_s;
					state_q   <= C_FIN;
				end
				C_FIN: begin
					left_f_q <= f_q;
					left_t_q <= t_q;
					left_s_q <= score_new;
					if (last_cell) begin
						pos_q   <= '0;
						row_q   <= '0;
						col_q   <= '0;
						ti_q    <= RW'(rows_q - SW'(1));
						tj_q    <= CW'(cols_q - SW'(1));
						k_q     <= '0;
						state_q <= (rows_q == SW'(1) && cols_q == SW'(1)) ? E_RD : T_RD;
					end else begin
						pos_q <= pos_q + PW'(1);
						if (SW'(col_q) + SW'(1) == cols_q) begin
							col_q <= '0;
							row_q <= row_q + RW'(1);
						end else begin
							col_q <= col_q + CW'(1);
						end
						state_q <= IDLE;
					end
				end
				T_RD: begin
					state_q <= T_STEP;
				end
				T_STEP: begin
					ti_q <= ti_next;
					tj_q <= tj_next;
					state_q <= (ti_next == '0 && tj_next == '0) ? E_RD : T_RD;
				end
				E_RD: begin
					state_q <= E_LOAD;
				end
				E_LOAD: begin
					out_valid_q <= 1'b1;
					step_q      <= k_q;
					prow_q      <= emit_row;
					pcol_q      <= k_q + SW'(2) - emit_row;
					last_q      <= (k_q == count_m1[SW-1:0]);
					state_q     <= E_WAIT;
				end
				E_WAIT: begin
					if (trace.ready) begin
						out_valid_q <= 1'b0;
						if (last_q) begin
							state_q <= IDLE;
						end else begin
							k_q     <= k_q + SW'(1);
							state_q <= E_RD;
						end
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase

			// size writes restart the position realignment
			if (cfg_we) begin
				dirty_q <= 1'b1;
				case (cfg_index)
					gmapt_pkg::CFG_ROW_COUNT: rows_q <= clamp_size(cfg_data, SW'(MAX_ROWS));
					gmapt_pkg::CFG_COL_COUNT: cols_q <= clamp_size(cfg_data, SW'(MAX_COLS));
					default: ;
				endcase
				if (state_q == N_LIM || state_q == N_CHK || state_q == N_DIV)
					state_q <= N_LIM;
			end
		end
	end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for grid_max_area_path_traceback, grids of rate pairs in,
// traced path words out, each word checked against a built-in score/decision predictor
// depends on gmapt_pkg, gmapt_if and the block itself
module tb;

	localparam int MAX_ROWS    = 32;
	localparam int MAX_COLS    = 32;
	localparam int SW          = gmapt_pkg::SIZE_W;
	localparam int SETTLE      = 40;
	localparam int CYCLE_LIMIT = 2000000;

	// rate patterns for generated grids
	localparam int RATE_ANY      = 0;
	localparam int RATE_IN_RANGE = 1;
	localparam int RATE_LEVELS   = 2;
	localparam int RATE_FIXED    = 3;

	typedef struct packed {
		gmapt_pkg::size_t step_index;
		gmapt_pkg::size_t path_row;
		gmapt_pkg::size_t path_col;
		logic             is_last;
	} path_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [gmapt_pkg::CFG_IDX_W-1:0] cfg_index;
	gmapt_pkg::size_t cfg_data;

	gmapt_in_if  grid_ch();
	gmapt_out_if trace_ch();

	grid_max_area_path_traceback #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) i_dut (
		.clk, .arst_n, .grid(grid_ch), .trace(trace_ch), .cfg_we, .cfg_index, .cfg_data);

	// predictor state
	gmapt_pkg::size_t  row_reg = 6'd32;
	gmapt_pkg::size_t  col_reg = 6'd32;
	bit                from_above [MAX_ROWS*MAX_COLS];
	gmapt_pkg::rate_t  upper_fpr [MAX_COLS] = '{default: '0};
	gmapt_pkg::rate_t  upper_tpr [MAX_COLS] = '{default: '0};
	gmapt_pkg::score_t upper_score [MAX_COLS] = '{default: '0};
	gmapt_pkg::rate_t  left_fpr = '0;
	gmapt_pkg::rate_t  left_tpr = '0;
	gmapt_pkg::score_t left_score = '0;
	int unsigned       next_cell = 0;
	path_word_t        path_words_due[$];

	int src_idle_pct = 37;
	int snk_idle_pct = 85;
	int fail_count = 0;
	int cycle_count = 0;

	always #5 clk = ~clk;

	function automatic int unsigned clamp_size(gmapt_pkg::size_t v, int unsigned maxv);
		if (v == 0)
			return 1;
		if (v > maxv)
			return maxv;
		return 32'(v);
	endfunction

	// neighbour score plus floor((f - fn) * (t + tn) / 2), saturated to 40 bits
	function automatic gmapt_pkg::score_t extend_score(gmapt_pkg::score_t base,
		gmapt_pkg::rate_t f, gmapt_pkg::rate_t t, gmapt_pkg::rate_t fn,
		gmapt_pkg::rate_t tn);
		longint d, s, total;
		d = longint'(f) - longint'(fn);
		s = longint'(t) + longint'(tn);
		total = longint'(base) + ((d * s) >>> 1);
		if (total > longint'(gmapt_pkg::SCORE_MAX))
			total = gmapt_pkg::SCORE_MAX;
		else if (total < longint'(gmapt_pkg::SCORE_MIN))
			total = gmapt_pkg::SCORE_MIN;
		return gmapt_pkg::score_t'(total);
	endfunction

	function automatic void score_cell(gmapt_pkg::rate_t f, gmapt_pkg::rate_t t);
		int unsigned rows, cols, row, col, i, j, count;
		gmapt_pkg::score_t score, from_up, from_left;
		gmapt_pkg::size_t trail [MAX_ROWS+MAX_COLS-1];
		path_word_t w;
		rows = clamp_size(row_reg, MAX_ROWS);
		cols = clamp_size(col_reg, MAX_COLS);
		if (next_cell >= rows * cols)
			next_cell = 0;
		row = next_cell / cols;
		col = next_cell % cols;
		from_up = extend_score(upper_score[col], f, t, upper_fpr[col], upper_tpr[col]);
		from_left = extend_score(left_score, f, t, left_fpr, left_tpr);
		if (row == 0 && col == 0) begin
			score = extend_score('0, f, t, '0, '0);
		end else if (row == 0) begin
			score = from_left;
			from_above[row*MAX_COLS+col] = 1'b0;
		end else if (col == 0 || !(from_up < from_left)) begin
			// tie goes to the cell above
			score = from_up;
			from_above[row*MAX_COLS+col] = 1'b1;
		end else begin
			score = from_left;
			from_above[row*MAX_COLS+col] = 1'b0;
		end
		upper_fpr[col] = f;
		upper_tpr[col] = t;
		upper_score[col] = score;
		left_fpr = f;
		left_tpr = t;
		left_score = score;
		next_cell++;
		if (next_cell < rows * cols)
			return;
		next_cell = 0;

		i = rows - 1;
		j = cols - 1;
		while (i > 0 || j > 0) begin
			trail[i+j] = gmapt_pkg::size_t'(i + 1);
			if (i >= 1 && from_above[i*MAX_COLS+j])
				i--;
			else
				j--;
		end
		trail[0] = 6'd1;
		count = rows + cols - 1;
		for (int k = 0; k < count; k++) begin
			w.step_index = gmapt_pkg::size_t'(k);
			w.path_row = trail[k];
			w.path_col = gmapt_pkg::size_t'(k + 2 - int'(trail[k]));
			w.is_last = (k == count - 1);
			path_words_due.push_back(w);
		end
	endfunction

	function automatic bit field_ok(string name, logic [SW-1:0] want, logic [SW-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// path word checker
	always @(posedge clk) begin
		path_word_t want;
		bit ok;
		if (arst_n && trace_ch.valid && trace_ch.ready) begin
			if (path_words_due.size() == 0) begin
				$error("unexpected word: step %0d row %0d col %0d last %0b",
					trace_ch.step_index, trace_ch.path_row, trace_ch.path_col,
					trace_ch.is_last);
				fail_count++;
			end else begin
				want = path_words_due.pop_front();
				ok = field_ok("step_index", want.step_index, trace_ch.step_index);
				ok &= field_ok("path_row", want.path_row, trace_ch.path_row);
				ok &= field_ok("path_col", want.path_col, trace_ch.path_col);
				ok &= field_ok("is_last", SW'(want.is_last), SW'(trace_ch.is_last));
				if (!ok)
					fail_count++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** grid_max_area_path_traceback: FAILED **");
			$finish;
		end
	end

	initial begin
		trace_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			trace_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	// called at a falling edge, returns at a falling edge with valid still high
	task automatic send_cell(gmapt_pkg::rate_t f, gmapt_pkg::rate_t t);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			grid_ch.valid <= 1'b0;
			@(negedge clk);
		end
		grid_ch.valid <= 1'b1;
		grid_ch.fpr_value <= f;
		grid_ch.tpr_value <= t;
		do
			@(posedge clk);
		while (!grid_ch.ready);
		score_cell(f, t);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [gmapt_pkg::CFG_IDX_W-1:0] idx, gmapt_pkg::size_t value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx == gmapt_pkg::CFG_ROW_COUNT)
			row_reg = value;
		else
			col_reg = value;
	endtask

	task automatic wait_drained();
		grid_ch.valid <= 1'b0;
		while (path_words_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// any 16-bit value, in range, few levels for ties, or one value
	function automatic gmapt_pkg::rate_t pick_rate(int mode, gmapt_pkg::rate_t fixed);
		case (mode)
			RATE_ANY: return gmapt_pkg::rate_t'($urandom_range(0, 65535));
			RATE_IN_RANGE: return gmapt_pkg::rate_t'($urandom_range(0, 32768));
			RATE_LEVELS: return gmapt_pkg::rate_t'($urandom_range(0, 2) * 16384);
			default: return fixed;
		endcase
	endfunction

	task automatic send_grid(int mode);
		int unsigned cells;
		gmapt_pkg::rate_t fixed_f, fixed_t;
		cells = clamp_size(row_reg, MAX_ROWS) * clamp_size(col_reg, MAX_COLS);
		fixed_f = pick_rate(RATE_IN_RANGE, '0);
		fixed_t = pick_rate(RATE_IN_RANGE, '0);
		repeat (cells) send_cell(pick_rate(mode, fixed_f), pick_rate(mode, fixed_t));
	endtask

	// first row of the default grid, then two rows so the grid ends at the next row
	task automatic test_reset_size();
		repeat (MAX_COLS) send_cell(pick_rate(RATE_IN_RANGE, '0), pick_rate(RATE_IN_RANGE, '0));
		wait_drained();
		write_reg(gmapt_pkg::CFG_ROW_COUNT, 6'd2);
		repeat (MAX_COLS) send_cell(pick_rate(RATE_ANY, '0), pick_rate(RATE_ANY, '0));
		wait_drained();
	endtask

	task automatic test_single_cell();
		write_reg(gmapt_pkg::CFG_ROW_COUNT, 6'd1);
		write_reg(gmapt_pkg::CFG_COL_COUNT, 6'd1);
		send_cell(16'd32768, 16'd32768);
		send_cell(16'd0, 16'd0);
		wait_drained();
		// zero sizes act as one
		write_reg(gmapt_pkg::CFG_ROW_COUNT, 6'd0);
		write_reg(gmapt_pkg::CFG_COL_COUNT, 6'd0);
		send_cell(16'hFFFF, 16'hFFFF);
		wait_drained();
	endtask

	task automatic test_ties();
		write_reg(gmapt_pkg::CFG_ROW_COUNT, 6'd2);
		write_reg(gmapt_pkg::CFG_COL_COUNT, 6'd2);
		repeat (4) send_cell(16'd0, 16'd0);
		wait_drained();
		write_reg(gmapt_pkg::CFG_ROW_COUNT, 6'd3);
		write_reg(gmapt_pkg::CFG_COL_COUNT, 6'd3);
		repeat (9) send_cell(16'd32768, 16'd32768);
		wait_drained();
	endtask

	task automatic test_thin_grids();
		write_reg(gmapt_pkg::CFG_ROW_COUNT, 6'd1);
		write_reg(gmapt_pkg::CFG_COL_COUNT, 6'd3);
		send_grid(RATE_IN_RANGE);
		wait_drained();
		write_reg(gmapt_pkg::CFG_ROW_COUNT, 6'd3);
		write_reg(gmapt_pkg::CFG_COL_COUNT, 6'd1);
		send_grid(RATE_IN_RANGE);
		wait_drained();
		// sizes above the maximum clamp
		write_reg(gmapt_pkg::CFG_ROW_COUNT, 6'd63);
		send_grid(RATE_ANY);
		wait_drained();
		write_reg(gmapt_pkg::CFG_ROW_COUNT, 6'd1);
		write_reg(gmapt_pkg::CFG_COL_COUNT, 6'd40);
		send_grid(RATE_ANY);
		wait_drained();
	endtask

	task automatic test_rate_extremes();
		write_reg(gmapt_pkg::CFG_ROW_COUNT, 6'd2);
		write_reg(gmapt_pkg::CFG_COL_COUNT, 6'd3);
		send_cell(16'hFFFF, 16'd0);
		send_cell(16'd0, 16'hFFFF);
		send_cell(16'd32768, 16'd1);
		send_cell(16'd1, 16'd32768);
		send_cell(16'd32769, 16'hFFFF);
		send_cell(16'd0, 16'd0);
		wait_drained();
	endtask

	task automatic test_resize_mid_grid();
		write_reg(gmapt_pkg::CFG_ROW_COUNT, 6'd3);
		write_reg(gmapt_pkg::CFG_COL_COUNT, 6'd4);
		repeat (7) send_cell(pick_rate(RATE_IN_RANGE, '0), pick_rate(RATE_IN_RANGE, '0));
		wait_drained();
		// position now past the end of the new grid: restarts at the corner
		write_reg(gmapt_pkg::CFG_ROW_COUNT, 6'd2);
		write_reg(gmapt_pkg::CFG_COL_COUNT, 6'd2);
		send_grid(RATE_IN_RANGE);
		wait_drained();
		write_reg(gmapt_pkg::CFG_COL_COUNT, 6'd3);
		repeat (3) send_cell(pick_rate(RATE_IN_RANGE, '0), pick_rate(RATE_IN_RANGE, '0));
		wait_drained();
		// more rows, same width: the grid carries on
		write_reg(gmapt_pkg::CFG_ROW_COUNT, 6'd4);
		repeat (9) send_cell(pick_rate(RATE_IN_RANGE, '0), pick_rate(RATE_IN_RANGE, '0));
		wait_drained();
	endtask

	// keeps a grid at or under 64 cells whatever the other size is
	function automatic gmapt_pkg::size_t pick_size(int unsigned other);
		case ($urandom_range(0, 9))
			0: return 6'd0;
			1: return (other <= 2) ? gmapt_pkg::size_t'($urandom_range(33, 63)) : 6'd1;
			2: return (other <= 2) ? gmapt_pkg::size_t'($urandom_range(7, 32)) : 6'd2;
			default: return (other <= 6) ? gmapt_pkg::size_t'($urandom_range(1, 6)) :
				gmapt_pkg::size_t'($urandom_range(1, 2));
		endcase
	endfunction

	task automatic test_random_grids(int n_items, int src_pct, int snk_pct);
		int sent;
		gmapt_pkg::size_t v;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		sent = 0;
		while (sent < n_items) begin
			// otherwise the next grid is offered straight away and waits until the trace has gone out
			if ($urandom_range(0, 99) < 60) begin
				wait_drained();
				if ($urandom_range(0, 1)) begin
					v = pick_size(1);
					write_reg(gmapt_pkg::CFG_ROW_COUNT, v);
					write_reg(gmapt_pkg::CFG_COL_COUNT, pick_size(clamp_size(v, MAX_ROWS)));
				end else if ($urandom_range(0, 1)) begin
					write_reg(gmapt_pkg::CFG_ROW_COUNT,
						pick_size(clamp_size(col_reg, MAX_COLS)));
				end else begin
					write_reg(gmapt_pkg::CFG_COL_COUNT,
						pick_size(clamp_size(row_reg, MAX_ROWS)));
				end
			end
			send_grid($urandom_range(RATE_ANY, RATE_FIXED));
			sent += clamp_size(row_reg, MAX_ROWS) * clamp_size(col_reg, MAX_COLS);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = gmapt_pkg::CFG_ROW_COUNT;
		cfg_data = '0;
		grid_ch.valid = 1'b0;
		grid_ch.fpr_value = '0;
		grid_ch.tpr_value = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_size();
		test_single_cell();
		test_ties();
		test_thin_grids();
		test_rate_extremes();
		test_resize_mid_grid();
		test_random_grids(60, 37, 85);
		test_random_grids(60, 85, 37);
		test_random_grids(50, 0, 0);
		wait_drained();

		if (fail_count == 0)
			$display("** grid_max_area_path_traceback: PASSED **");
		else
			$display("** grid_max_area_path_traceback: FAILED **");
		$finish;
	end

endmodule

// File: grid_max_area_path_traceback.f
src/gmapt_pkg.sv
src/gmapt_if.sv
src/grid_max_area_path_traceback.sv
test/tb.sv
